[rtl/bcc_pkg.sv]
// shared types, tables and the base judging function of the composition counter
`default_nettype none
package bcc_pkg;

  localparam int CountBits  = 32;
  localparam int NumClasses = 11;
  localparam int ResBits    = 32;
  localparam int EvqDepth   = 4;
  localparam int EvqAw      = $clog2(EvqDepth);

  localparam logic [3:0] CodeC = 4'd2;
  localparam logic [3:0] CodeG = 4'd4;
  localparam logic [3:0] CodeR = 4'd5;
  localparam logic [3:0] CodeY = 4'd10;
  localparam logic [3:0] CodeN = 4'd15;

  localparam logic [3:0] ClsA            = 4'd0;
  localparam logic [3:0] ClsC            = 4'd1;
  localparam logic [3:0] ClsG            = 4'd2;
  localparam logic [3:0] ClsT            = 4'd3;
  localparam logic [3:0] ClsTwoWay       = 4'd4;
  localparam logic [3:0] ClsThreeWay     = 4'd5;
  localparam logic [3:0] ClsFourWay      = 4'd6;
  localparam logic [3:0] ClsCpg          = 4'd7;
  localparam logic [3:0] ClsTransversion = 4'd8;
  localparam logic [3:0] ClsTransition   = 4'd9;
  localparam logic [3:0] ClsCpgTransition = 4'd10;

  localparam logic [3:0] LetterCode [32] = '{
    4'd15, 4'd1, 4'd14, 4'd2, 4'd13, 4'd15, 4'd15, 4'd4,
    4'd11, 4'd15, 4'd15, 4'd12, 4'd15, 4'd3, 4'd15, 4'd15,
    4'd15, 4'd15, 4'd5, 4'd6, 4'd8, 4'd15, 4'd7, 4'd9,
    4'd0, 4'd10, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15
  };

  localparam logic [3:0] SingleClass [16] = '{
    4'd4, 4'd0, 4'd1, 4'd4, 4'd2, 4'd4, 4'd4, 4'd4,
    4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
  };

  localparam logic [2:0] Degeneracy [16] = '{
    3'd4, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  typedef logic [NumClasses-1:0] cls_mask_t;

  typedef struct packed {
    cls_mask_t mask_a;
    cls_mask_t mask_b;
    logic      last;
  } ev_t;

  typedef logic [NumClasses-1:0][ResBits-1:0] res_t;

  function automatic logic [3:0] char_code(input logic [7:0] ch);
    logic [3:0] code;
    code = CodeN;
    if (ch[7:6] == 2'b01) code = LetterCode[ch[4:0]];
    return code;
  endfunction

  function automatic logic is_cy(input logic [3:0] code);
    return (code == CodeC) || (code == CodeY);
  endfunction

  function automatic logic is_gr(input logic [3:0] code);
    return (code == CodeG) || (code == CodeR);
  endfunction

  function automatic cls_mask_t judge_mask(
    input logic [3:0] b,
    input logic       upper,
    input logic       counted,
    input logic       valid,
    input logic [3:0] bef,
    input logic       bef_valid,
    input logic [3:0] nxt,
    input logic       caps_mode
  );
    logic [2:0] deg;
    logic       cpg;
    logic       ts;
    cls_mask_t  m;
    deg = Degeneracy[b];
    ts  = (b == CodeY) || (b == CodeR);
    cpg = 1'b0;
    m   = '0;
    if (is_cy(b)) cpg = is_gr(nxt);
    else if (is_gr(b)) cpg = bef_valid && is_cy(bef);
    case (deg)
      3'd1: m[SingleClass[b]] = 1'b1;
      3'd2: m[ClsTwoWay] = 1'b1;
      3'd3: m[ClsThreeWay] = 1'b1;
      3'd4: m[ClsFourWay] = 1'b1;
      default: m = '0;
    endcase
    if (ts) m[ClsTransition] = 1'b1;
    else if (deg == 3'd2) m[ClsTransversion] = 1'b1;
    if (cpg) begin
      m[ClsCpg] = 1'b1;
      if (ts) m[ClsCpgTransition] = 1'b1;
    end
    if (!valid || !counted || (caps_mode && !upper)) m = '0;
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/bcc_front.sv]
// front end: character decode, hold stage and per-item class masks
`default_nettype none
module bcc_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic        q_full,
  input  wire logic [7:0]  base_char,
  input  wire logic        counted,
  input  wire logic        last_of_region,
  input  wire logic        caps_mode,
  output logic             ev_push,
  output bcc_pkg::ev_t     ev
);
  import bcc_pkg::*;

  logic [3:0] before_code_r, before_code_nxt;
  logic       before_valid_r, before_valid_nxt;
  logic [3:0] held_code_r, held_code_nxt;
  logic       held_upper_r, held_upper_nxt;
  logic       held_counted_r, held_counted_nxt;
  logic       held_valid_r, held_valid_nxt;

  logic [3:0] code;
  logic       upper;

  assign code    = char_code(base_char);
  assign upper   = (base_char >= 8'h41) && (base_char <= 8'h5A);
  assign ev_push = push && !q_full;

  always_comb begin
    ev.mask_a = judge_mask(held_code_r, held_upper_r, held_counted_r, held_valid_r,
                           before_code_r, before_valid_r, code, caps_mode);
    ev.mask_b = '0;
    if (last_of_region) begin
      ev.mask_b = judge_mask(code, upper, counted, 1'b1,
                             held_code_r, held_valid_r, CodeN, caps_mode);
    end
    ev.last = last_of_region;
  end

  always_comb begin
    before_code_nxt  = before_code_r;
    before_valid_nxt = before_valid_r;
    held_code_nxt    = held_code_r;
    held_upper_nxt   = held_upper_r;
    held_counted_nxt = held_counted_r;
    held_valid_nxt   = held_valid_r;
    if (ev_push) begin
      if (last_of_region) begin
        before_code_nxt  = '0;
        before_valid_nxt = 1'b0;
        held_code_nxt    = '0;
        held_upper_nxt   = 1'b0;
        held_counted_nxt = 1'b0;
        held_valid_nxt   = 1'b0;
      end else begin
        before_code_nxt  = held_code_r;
        before_valid_nxt = held_valid_r;
        held_code_nxt    = code;
        held_upper_nxt   = upper;
        held_counted_nxt = counted;
        held_valid_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      before_code_r  <= '0;
      before_valid_r <= 1'b0;
      held_code_r    <= '0;
      held_upper_r   <= 1'b0;
      held_counted_r <= 1'b0;
      held_valid_r   <= 1'b0;
    end else begin
      before_code_r  <= before_code_nxt;
      before_valid_r <= before_valid_nxt;
      held_code_r    <= held_code_nxt;
      held_upper_r   <= held_upper_nxt;
      held_counted_r <= held_counted_nxt;
      held_valid_r   <= held_valid_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/bcc_evq.sv]
// event queue between front end and counter bank
`default_nettype none
module bcc_evq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire bcc_pkg::ev_t wr_ev,
  output logic             q_full,
  input  wire logic        rd_en,
  output logic             rd_valid,
  output bcc_pkg::ev_t     rd_ev
);
  import bcc_pkg::*;

  ev_t              mem_r [EvqDepth];
  logic [EvqAw-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [EvqAw-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [EvqAw:0]   cnt_r, cnt_nxt;

  assign q_full   = (cnt_r == (EvqAw+1)'(EvqDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_ev    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) wr_ptr_nxt = wr_ptr_r + 1'b1;
    if (rd_en) rd_ptr_nxt = rd_ptr_r + 1'b1;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    else if (!wr_en && rd_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/bcc_back.sv]
// back end: saturating class counters and two-entry result queue
`default_nettype none
module bcc_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        ev_valid,
  input  wire bcc_pkg::ev_t ev_head,
  output logic             ev_pop,
  input  wire logic        pop,
  output logic             empty,
  output bcc_pkg::res_t    res
);
  import bcc_pkg::*;

  localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};

  logic [CountBits-1:0] cnt_r [NumClasses];
  logic [CountBits-1:0] cnt_nxt [NumClasses];
  logic [CountBits-1:0] sat [NumClasses];
  logic [CountBits:0]   sum [NumClasses];
  logic [1:0]           add [NumClasses];
  res_t                 res_new;

  res_t       resq_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       res_push;
  logic       res_pop;

  assign ev_pop   = ev_valid && (!ev_head.last || (ocnt_r != 2'd2));
  assign res_push = ev_pop && ev_head.last;
  assign res_pop  = pop && !empty;
  assign empty    = (ocnt_r == 2'd0);
  assign res      = resq_r[rd_ptr_r];

  always_comb begin
    for (int k = 0; k < NumClasses; k++) begin
      add[k] = {1'b0, ev_head.mask_a[k]} + {1'b0, ev_head.mask_b[k]};
      sum[k] = {1'b0, cnt_r[k]} + (CountBits+1)'(add[k]);
      sat[k] = (sum[k] > {1'b0, CntMax}) ? CntMax : sum[k][CountBits-1:0];
      res_new[k] = ResBits'(sat[k]);
      cnt_nxt[k] = cnt_r[k];
      if (ev_pop) cnt_nxt[k] = ev_head.last ? '0 : sat[k];
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    ocnt_nxt   = ocnt_r;
    if (res_push) wr_ptr_nxt = ~wr_ptr_r;
    if (res_pop) rd_ptr_nxt = ~rd_ptr_r;
    if (res_push && !res_pop) ocnt_nxt = ocnt_r + 2'd1;
    else if (!res_push && res_pop) ocnt_nxt = ocnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (res_push) resq_r[wr_ptr_r] <= res_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NumClasses; k++) cnt_r[k] <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      ocnt_r   <= 2'd0;
    end else begin
      for (int k = 0; k < NumClasses; k++) cnt_r[k] <= cnt_nxt[k];
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      ocnt_r   <= ocnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/base_composition_counter.sv]
// top level of the nucleotide composition counter
//
// channel   ports                                       transfer when
// input     push full in_base_char in_counted ...       push && !full
// result    empty pop out_count_a .. out_count_cpg_...  pop && !empty
// config    psel penable pwrite paddr pwdata prdata     psel && penable && pwrite
//
// one item per cycle while full is low; a base is judged when its right neighbour arrives
// region close needs a free slot in the two-entry result queue
// four-entry event queue lets input and result sides stall on their own
// the closing item is registered in the event queue, then its result in the result queue
// synchronous reset clears control state
`default_nettype none
module base_composition_counter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_base_char,
  input  wire logic        in_counted,
  input  wire logic        in_last_of_region,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_count_a,
  output logic [31:0]      out_count_c,
  output logic [31:0]      out_count_g,
  output logic [31:0]      out_count_t,
  output logic [31:0]      out_count_two_way,
  output logic [31:0]      out_count_three_way,
  output logic [31:0]      out_count_four_way,
  output logic [31:0]      out_count_cpg,
  output logic [31:0]      out_count_transversion,
  output logic [31:0]      out_count_transition,
  output logic [31:0]      out_count_cpg_transition,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bcc_pkg::*;

  localparam logic RegUpperCaseOnly = 1'b0;

  logic caps_mode_r, caps_mode_nxt;
  logic ev_push;
  ev_t  ev_in;
  logic ev_valid;
  ev_t  ev_head;
  logic ev_pop;
  res_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegUpperCaseOnly) ? {31'b0, caps_mode_r} : '0;

  always_comb begin
    caps_mode_nxt = caps_mode_r;
    if (psel && penable && pwrite && pready && (paddr[2] == RegUpperCaseOnly)) begin
      caps_mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) caps_mode_r <= 1'b0;
    else caps_mode_r <= caps_mode_nxt;
  end

  bcc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .q_full         (full),
    .base_char      (in_base_char),
    .counted        (in_counted),
    .last_of_region (in_last_of_region),
    .caps_mode      (caps_mode_r),
    .ev_push        (ev_push),
    .ev             (ev_in)
  );

  bcc_evq u_evq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ev_push),
    .wr_ev    (ev_in),
    .q_full   (full),
    .rd_en    (ev_pop),
    .rd_valid (ev_valid),
    .rd_ev    (ev_head)
  );

  bcc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (ev_valid),
    .ev_head  (ev_head),
    .ev_pop   (ev_pop),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign out_count_a              = res[ClsA];
  assign out_count_c              = res[ClsC];
  assign out_count_g              = res[ClsG];
  assign out_count_t              = res[ClsT];
  assign out_count_two_way        = res[ClsTwoWay];
  assign out_count_three_way      = res[ClsThreeWay];
  assign out_count_four_way       = res[ClsFourWay];
  assign out_count_cpg            = res[ClsCpg];
  assign out_count_transversion   = res[ClsTransversion];
  assign out_count_transition     = res[ClsTransition];
  assign out_count_cpg_transition = res[ClsCpgTransition];

`ifndef ASSERT_OFF
  a_close_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ev_pop && ev_head.last |=> !empty)
    else $error("region close did not produce a result");

  a_result_from_close: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> $past(ev_pop && ev_head.last))
    else $error("result appeared without a region close");

  a_event_per_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push == (push && !full))
    else $error("event queue write does not follow input transfer");

  a_no_pop_when_dry: assert property (@(posedge clk) disable iff (!rst_n)
    ev_pop |-> ev_valid)
    else $error("counter bank consumed from an empty event queue");
`endif

endmodule
`default_nettype wire
